### hw/rtl/nts_pkg.sv
`default_nettype none
package nts_pkg;

    localparam int BUF_CHARS = 64;
    localparam int ADDR_W = $clog2(BUF_CHARS);
    localparam int CNT_W = $clog2(BUF_CHARS + 1);
    localparam int MUL_STEPS = ADDR_W;
    localparam int STEP_W = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;

    localparam logic [7:0] LETTER_BASE = 8'h41;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       overflow;
    } out_item_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } mem_ctl_t;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] x;
        logic [ADDR_W-1:0] y;
        logic [CNT_W-1:0]  len;
    } mm_req_t;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] prod;
    } mm_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXP_RD,
        ST_EXP_W1,
        ST_EXP_W2,
        ST_SW_START,
        ST_SW_WAIT,
        ST_SW_RD,
        ST_SW_CHK,
        ST_SW_WI,
        ST_SW_WJ,
        ST_PK_RD,
        ST_PK_W,
        ST_OUT_RD,
        ST_OUT_EM
    } state_t;

    function automatic logic is_blocked(input logic [7:0] c);
        return (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_NUL);
    endfunction

endpackage
`default_nettype wire

### hw/rtl/nts_buf.sv
`default_nettype none
module nts_buf (
    input  wire logic             clk,
    input  wire nts_pkg::mem_ctl_t ctl,
    output logic [7:0]            rdata_a,
    output logic [7:0]            rdata_b
);

    logic [7:0] mem [nts_pkg::BUF_CHARS];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            rdata_a <= mem[ctl.raddr_a];
            rdata_b <= mem[ctl.raddr_b];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/nts_modmul.sv
`default_nettype none
module nts_modmul (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire nts_pkg::mm_req_t req,
    output nts_pkg::mm_rsp_t      rsp
);

    localparam logic [nts_pkg::STEP_W-1:0] LastStep = nts_pkg::STEP_W'(nts_pkg::MUL_STEPS - 1);
    localparam logic [nts_pkg::STEP_W-1:0] StepOne = 1;

    logic                         busy_reg;
    logic                         done_reg;
    logic [nts_pkg::STEP_W-1:0]   cnt_reg;
    logic [nts_pkg::ADDR_W-1:0]   acc_reg;
    logic [nts_pkg::ADDR_W-1:0]   acc_next;
    logic [nts_pkg::ADDR_W-1:0]   x_reg;
    logic [nts_pkg::ADDR_W-1:0]   y_reg;
    logic [nts_pkg::CNT_W-1:0]    len_reg;

    logic [nts_pkg::CNT_W:0] len_x;
    logic [nts_pkg::CNT_W:0] t1;
    logic [nts_pkg::CNT_W:0] t1_red;
    logic [nts_pkg::CNT_W:0] t2;
    logic [nts_pkg::CNT_W:0] t2_red;

    // one double-and-add step modulo len, msb of the multiplier first
    always_comb
    begin
        len_x  = {1'b0, len_reg};
        t1     = {{(nts_pkg::CNT_W - nts_pkg::ADDR_W){1'b0}}, acc_reg, 1'b0};
        t1_red = (t1 >= len_x) ? (t1 - len_x) : t1;
        t2     = t1_red;
        if (y_reg[nts_pkg::ADDR_W-1])
        begin
            t2 = t1_red + {{(nts_pkg::CNT_W + 1 - nts_pkg::ADDR_W){1'b0}}, x_reg};
        end
        t2_red   = (t2 >= len_x) ? (t2 - len_x) : t2;
        acc_next = t2_red[nts_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + StepOne;
            if (cnt_reg == LastStep)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            x_reg   <= req.x;
            y_reg   <= req.y;
            len_reg <= req.len;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[nts_pkg::ADDR_W-2:0], 1'b0};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule
`default_nettype wire

### hw/rtl/nibble_text_scramble_codec_top.sv
// after the last item, encode expands each byte into two letters (states EXP_RD, EXP_W1, EXP_W2),
// then swaps each letter, then reads and emits each result byte
// decode swaps each letter, packs each letter pair into a byte, then reads and emits each result
// each swap is set by the shared modulo multiply unit: 3 products of 6 steps each
// throughput: non-last items are taken one per cycle; busy holds while a message is processed
// reset clears the control state, fill count, drop flag and direction; buffer is not cleared
`default_nettype none
module nibble_text_scramble_codec_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire nts_pkg::in_item_t  item,
    output logic                    strobe,
    output nts_pkg::out_item_t      result,
    input  wire logic               cfg_we,
    input  wire logic               cfg_data
);

    localparam logic [nts_pkg::CNT_W-1:0] CntOne = 1;
    localparam logic [nts_pkg::CNT_W-1:0] CntFull = nts_pkg::CNT_W'(nts_pkg::BUF_CHARS);
    localparam logic [nts_pkg::CNT_W-1:0] CntHalf = nts_pkg::CNT_W'(nts_pkg::BUF_CHARS / 2);
    localparam logic [1:0] PassLast = 2'd2;

    nts_pkg::state_t state_reg;
    nts_pkg::state_t state_next;

    logic                       dir_reg;
    logic [nts_pkg::CNT_W-1:0]  fill_reg;
    logic [nts_pkg::CNT_W-1:0]  fill_next;
    logic                       dropped_reg;
    logic                       dropped_next;
    logic                       run_dir_reg;
    logic                       run_dir_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic [nts_pkg::CNT_W-1:0]  len_reg;
    logic [nts_pkg::CNT_W-1:0]  len_next;
    logic [nts_pkg::CNT_W-1:0]  cnt_reg;
    logic [nts_pkg::CNT_W-1:0]  cnt_next;
    logic [nts_pkg::CNT_W-1:0]  idx_reg;
    logic [nts_pkg::CNT_W-1:0]  idx_next;
    logic [1:0]                 pass_reg;
    logic [1:0]                 pass_next;
    logic [nts_pkg::ADDR_W-1:0] r_reg;
    logic [nts_pkg::ADDR_W-1:0] r_next;
    logic [nts_pkg::ADDR_W-1:0] j_reg;
    logic [nts_pkg::ADDR_W-1:0] j_next;

    nts_pkg::mem_ctl_t mem_ctl;
    nts_pkg::mm_req_t  mm_req;
    nts_pkg::mm_rsp_t  mm_rsp;
    logic [7:0]        rdata_a;
    logic [7:0]        rdata_b;

    logic                       accept;
    logic                       buf_full;
    logic [nts_pkg::CNT_W-1:0]  fill_after;
    logic [nts_pkg::CNT_W-1:0]  enc_m;
    logic [nts_pkg::CNT_W-1:0]  enc_len;
    logic [nts_pkg::CNT_W-1:0]  km1;
    logic                       swap_last;
    logic                       res_last;
    logic                       pk_last;
    logic                       blocked;
    logic [7:0]                 hi_off;
    logic [7:0]                 packed_byte;

    nts_buf u_buf (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    nts_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    always_comb
    begin
        accept     = start && (state_reg == nts_pkg::ST_IDLE);
        buf_full   = (fill_reg == CntFull);
        fill_after = buf_full ? fill_reg : (fill_reg + CntOne);
        enc_m      = (fill_after > CntHalf) ? CntHalf : fill_after;
        enc_len    = {enc_m[nts_pkg::CNT_W-2:0], 1'b0};
        km1        = idx_reg - CntOne;
        swap_last  = (run_dir_reg == nts_pkg::DIR_ENCODE) ? (idx_reg == (len_reg - CntOne))
                                                          : (idx_reg == '0);
        res_last   = (idx_reg == (cnt_reg - CntOne));
        pk_last    = res_last;
        blocked    = nts_pkg::is_blocked(rdata_a) || nts_pkg::is_blocked(rdata_b);
        hi_off     = rdata_a - nts_pkg::LETTER_BASE;
        packed_byte = {hi_off[3:0], 4'b0000} + rdata_b - nts_pkg::LETTER_BASE;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nts_pkg::ST_IDLE:
            begin
                if (accept && item.is_last)
                begin
                    state_next = (dir_reg == nts_pkg::DIR_ENCODE) ? nts_pkg::ST_EXP_RD
                                                                  : nts_pkg::ST_SW_START;
                end
            end
            nts_pkg::ST_EXP_RD:   state_next = nts_pkg::ST_EXP_W1;
            nts_pkg::ST_EXP_W1:   state_next = nts_pkg::ST_EXP_W2;
            nts_pkg::ST_EXP_W2:
            begin
                state_next = (idx_reg == CntOne) ? nts_pkg::ST_SW_START : nts_pkg::ST_EXP_RD;
            end
            nts_pkg::ST_SW_START: state_next = nts_pkg::ST_SW_WAIT;
            nts_pkg::ST_SW_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    state_next = (pass_reg == PassLast) ? nts_pkg::ST_SW_RD
                                                        : nts_pkg::ST_SW_START;
                end
            end
            nts_pkg::ST_SW_RD:    state_next = nts_pkg::ST_SW_CHK;
            nts_pkg::ST_SW_CHK,
            nts_pkg::ST_SW_WJ:
            begin
                if ((state_reg == nts_pkg::ST_SW_CHK) && !blocked)
                begin
                    state_next = nts_pkg::ST_SW_WI;
                end
                else if (!swap_last)
                begin
                    state_next = nts_pkg::ST_SW_START;
                end
                else if (run_dir_reg == nts_pkg::DIR_ENCODE)
                begin
                    state_next = nts_pkg::ST_OUT_RD;
                end
                else
                begin
                    state_next = (cnt_reg == '0) ? nts_pkg::ST_IDLE : nts_pkg::ST_PK_RD;
                end
            end
            nts_pkg::ST_SW_WI:    state_next = nts_pkg::ST_SW_WJ;
            nts_pkg::ST_PK_RD:    state_next = nts_pkg::ST_PK_W;
            nts_pkg::ST_PK_W:
            begin
                state_next = pk_last ? nts_pkg::ST_OUT_RD : nts_pkg::ST_PK_RD;
            end
            nts_pkg::ST_OUT_RD:   state_next = nts_pkg::ST_OUT_EM;
            nts_pkg::ST_OUT_EM:
            begin
                state_next = res_last ? nts_pkg::ST_IDLE : nts_pkg::ST_OUT_RD;
            end
            default:              state_next = nts_pkg::ST_IDLE;
        endcase
    end

    // outputs: memory, multiply unit, result, strobe and busy
    always_comb
    begin
        mem_ctl         = '0;
        mm_req          = '0;
        mm_req.len      = len_reg;
        mm_req.y        = idx_reg[nts_pkg::ADDR_W-1:0];
        mm_req.x        = (pass_reg == 2'd0) ? idx_reg[nts_pkg::ADDR_W-1:0] : r_reg;
        strobe          = 1'b0;
        result.out_byte = rdata_a;
        result.out_last = res_last;
        result.overflow = ovf_reg;
        busy            = (state_reg != nts_pkg::ST_IDLE);
        case (state_reg)
            nts_pkg::ST_IDLE:
            begin
                if (accept && !buf_full)
                begin
                    mem_ctl.we    = 1'b1;
                    mem_ctl.waddr = fill_reg[nts_pkg::ADDR_W-1:0];
                    mem_ctl.wdata = item.data_byte;
                end
            end
            nts_pkg::ST_EXP_RD:
            begin
                mem_ctl.re      = 1'b1;
                mem_ctl.raddr_a = km1[nts_pkg::ADDR_W-1:0];
            end
            nts_pkg::ST_EXP_W1:
            begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = {km1[nts_pkg::ADDR_W-2:0], 1'b1};
                mem_ctl.wdata = nts_pkg::LETTER_BASE + {4'b0000, rdata_a[3:0]};
            end
            nts_pkg::ST_EXP_W2:
            begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = {km1[nts_pkg::ADDR_W-2:0], 1'b0};
                mem_ctl.wdata = nts_pkg::LETTER_BASE + {4'b0000, rdata_a[7:4]};
            end
            nts_pkg::ST_SW_START:
            begin
                mm_req.start = 1'b1;
            end
            nts_pkg::ST_SW_RD:
            begin
                mem_ctl.re      = 1'b1;
                mem_ctl.raddr_a = idx_reg[nts_pkg::ADDR_W-1:0];
                mem_ctl.raddr_b = j_reg;
            end
            nts_pkg::ST_SW_WI:
            begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = idx_reg[nts_pkg::ADDR_W-1:0];
                mem_ctl.wdata = rdata_b;
            end
            nts_pkg::ST_SW_WJ:
            begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = j_reg;
                mem_ctl.wdata = rdata_a;
            end
            nts_pkg::ST_PK_RD:
            begin
                mem_ctl.re      = 1'b1;
                mem_ctl.raddr_a = {idx_reg[nts_pkg::ADDR_W-2:0], 1'b0};
                mem_ctl.raddr_b = {idx_reg[nts_pkg::ADDR_W-2:0], 1'b1};
            end
            nts_pkg::ST_PK_W:
            begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = idx_reg[nts_pkg::ADDR_W-1:0];
                mem_ctl.wdata = packed_byte;
            end
            nts_pkg::ST_OUT_RD:
            begin
                mem_ctl.re      = 1'b1;
                mem_ctl.raddr_a = idx_reg[nts_pkg::ADDR_W-1:0];
            end
            nts_pkg::ST_OUT_EM:
            begin
                strobe = 1'b1;
            end
            default:
            begin
                strobe = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        run_dir_next = run_dir_reg;
        ovf_next     = ovf_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        pass_next    = pass_reg;
        r_next       = r_reg;
        j_next       = j_reg;
        case (state_reg)
            nts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    fill_next    = fill_after;
                    dropped_next = dropped_reg || buf_full;
                    if (item.is_last)
                    begin
                        fill_next    = '0;
                        dropped_next = 1'b0;
                        run_dir_next = dir_reg;
                        pass_next    = 2'd0;
                        if (dir_reg == nts_pkg::DIR_ENCODE)
                        begin
                            ovf_next = dropped_reg || buf_full || (fill_after > CntHalf);
                            len_next = enc_len;
                            cnt_next = enc_len;
                            idx_next = enc_m;
                        end
                        else
                        begin
                            ovf_next = dropped_reg || buf_full;
                            len_next = fill_after;
                            cnt_next = {1'b0, fill_after[nts_pkg::CNT_W-1:1]};
                            idx_next = fill_after - CntOne;
                        end
                    end
                end
            end
            nts_pkg::ST_EXP_W2:
            begin
                idx_next = (idx_reg == CntOne) ? '0 : km1;
            end
            nts_pkg::ST_SW_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    if (pass_reg == PassLast)
                    begin
                        j_next    = mm_rsp.prod;
                        pass_next = 2'd0;
                    end
                    else
                    begin
                        r_next    = mm_rsp.prod;
                        pass_next = pass_reg + 2'd1;
                    end
                end
            end
            nts_pkg::ST_SW_CHK,
            nts_pkg::ST_SW_WJ:
            begin
                if ((state_reg == nts_pkg::ST_SW_WJ) || blocked)
                begin
                    if (swap_last)
                    begin
                        idx_next = '0;
                    end
                    else if (run_dir_reg == nts_pkg::DIR_ENCODE)
                    begin
                        idx_next = idx_reg + CntOne;
                    end
                    else
                    begin
                        idx_next = km1;
                    end
                end
            end
            nts_pkg::ST_PK_W:
            begin
                idx_next = pk_last ? '0 : (idx_reg + CntOne);
            end
            nts_pkg::ST_OUT_EM:
            begin
                idx_next = idx_reg + CntOne;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= nts_pkg::ST_IDLE;
            dir_reg     <= nts_pkg::DIR_ENCODE;
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
            run_dir_reg <= nts_pkg::DIR_ENCODE;
            len_reg     <= '0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            pass_reg    <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            dropped_reg <= dropped_next;
            run_dir_reg <= run_dir_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            pass_reg    <= pass_next;
            if (cfg_we)
            begin
                dir_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        r_reg   <= r_next;
        j_reg   <= j_next;
    end

endmodule
`default_nettype wire
